// ----- rtl/buddy_block_allocator_macros.svh -----
// assertion macros for the buddy block allocator
// depends on nothing; included by modules that carry assertions
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define BBA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/bba_pkg.sv -----
// shared types, constants and helpers of the buddy block allocator
// depends on nothing
`timescale 1ns / 1ps

package bba_pkg;

   localparam int unsigned POOL_BYTES  = 2097152;
   localparam int unsigned BLOCK_BYTES = 32;
   localparam int unsigned ORDERS      = 16;

   localparam int unsigned NBLK   = POOL_BYTES / BLOCK_BYTES;
   localparam int unsigned NODES  = 2 * NBLK - 1;
   localparam int unsigned BLK_W  = $clog2(NBLK);
   localparam int unsigned NODE_W = $clog2(NODES);
   localparam int unsigned MASK_W = ORDERS + 1;
   localparam int unsigned LVL_W  = $clog2(MASK_W);
   localparam int unsigned BSH    = $clog2(BLOCK_BYTES);
   localparam int unsigned SIZE_W = 22;
   localparam int unsigned OFF_W  = 21;
   localparam int unsigned ORD_W  = 5;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_BAD_FREE = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type            command;
      logic [SIZE_W-1:0]  size_bytes;
      logic [OFF_W-1:0]   free_offset;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [OFF_W-1:0]   block_offset;
      logic [ORD_W-1:0]   block_order;
   } rsp_type;

   // per-block record: set at an allocated start, with its order
   typedef struct packed {
      logic               allocated;
      logic [ORD_W-1:0]   order;
   } meta_type;

   // heap index of the tree node of a given order that holds block blk
   function automatic logic [NODE_W-1:0] node_index(input logic [LVL_W-1:0] k,
                                                    input logic [BLK_W-1:0] blk);
      logic [NODE_W-1:0] base;
      logic [NODE_W-1:0] pos;
      base = (NODE_W'(1) << (LVL_W'(ORDERS) - k)) - NODE_W'(1);
      pos  = NODE_W'(blk >> k);
      return base + pos;
   endfunction

   // smallest order whose block covers the size, capped at the top order
   function automatic logic [LVL_W-1:0] first_order(input logic [SIZE_W-1:0] size);
      logic [LVL_W-1:0] ord;
      logic [SIZE_W:0]  thr;
      ord = LVL_W'(ORDERS);
      for (int o = ORDERS; o >= 0; o--) begin
         thr = (SIZE_W + 1)'(BLOCK_BYTES) << o;
         if (thr >= {1'b0, size}) ord = LVL_W'(o);
      end
      return ord;
   endfunction

endpackage

// ----- rtl/bba_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
// depends on nothing
`timescale 1ns / 1ps

module bba_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/buddy_block_allocator.sv -----
// buddy block allocator top level: order-mask tree ram, block record ram, sequencer
// depends on bba_pkg, bba_ram and buddy_block_allocator_macros.svh
`timescale 1ns / 1ps
//
//   channel   ports                         transfer when
//   request   start, busy, req_payload      start high and busy low at a clock edge
//   response  rsp_valid, rsp_payload        rsp_valid high for one cycle
//
// each tree node holds a mask of the orders that have a free block in its subtree;
// allocate reads the root, walks down one level at a time, then rebuilds the path up
// level by level to the root, where the response is raised
// free reads its record, merges level by level, then rebuilds up the same way
// out-of-range requests answer in the next cycle; no space, or a free of a block
// that is not allocated, is answered from the state after the root or record read;
// the single read port of the tree ram sets the pace.
// after reset a clearing pass over every tree node and block record holds busy high
// the response cannot be stalled: it is shown for one cycle while busy is low

`include "buddy_block_allocator_macros.svh"

module buddy_block_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bba_pkg::req_type req_payload,
   output logic             rsp_valid,
   output bba_pkg::rsp_type rsp_payload
);
   import bba_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE,
      S_A_ROOT, S_A_DN, S_A_DNCHK, S_A_FOUND,
      S_F_CHK, S_F_MRG, S_F_MCHK, S_F_MCLR, S_F_SET,
      S_UP, S_UP_PAR, S_UP_WAIT
   } state_type;

   state_type         state_ff, state_in;
   cmd_type           op_ff, op_in;
   logic [LVL_W-1:0]  ord_ff, ord_in;
   logic [LVL_W-1:0]  tgt_ff, tgt_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [LVL_W-1:0]  lim_ff, lim_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [MASK_W-1:0] cm_ff, cm_in;
   logic [BLK_W-1:0]  blk_ff, blk_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              tree_we, tree_re;
   logic [NODE_W-1:0] tree_wa, tree_ra;
   logic [MASK_W-1:0] tree_wd, tree_rd;
   logic              meta_we, meta_re;
   logic [BLK_W-1:0]  meta_wa, meta_ra;
   meta_type          meta_wd, meta_rd;

   logic [NODE_W-1:0] sib, par, left;
   logic [MASK_W-1:0] cand, lvl_bit;
   logic [LVL_W-1:0]  low_k, fk;
   logic [OFF_W-1:0]  off;

   bba_ram #(.WIDTH(MASK_W), .DEPTH(NODES)) u_tree (
      .clock(clock), .wr_en(tree_we), .wr_addr(tree_wa), .wr_data(tree_wd),
      .rd_en(tree_re), .rd_addr(tree_ra), .rd_data(tree_rd)
   );

   bba_ram #(.WIDTH($bits(meta_type)), .DEPTH(NBLK)) u_meta (
      .clock(clock), .wr_en(meta_we), .wr_addr(meta_wa), .wr_data(meta_wd),
      .rd_en(meta_re), .rd_addr(meta_ra), .rd_data(meta_rd)
   );

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      sib     = cur_ff[0] ? cur_ff + NODE_W'(1) : cur_ff - NODE_W'(1);
      par     = (cur_ff - NODE_W'(1)) >> 1;
      left    = NODE_W'({cur_ff, 1'b1});
      lvl_bit = MASK_W'(1) << lvl_ff;
      off     = req_payload.free_offset;
      cand    = tree_rd & ~((MASK_W'(1) << ord_ff) - MASK_W'(1));
      low_k   = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (cand[i]) low_k = LVL_W'(i);
      end
      fk = (meta_rd.order > ORD_W'(ORDERS)) ? LVL_W'(ORDERS) : LVL_W'(meta_rd.order);
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ord_in       = ord_ff;
      tgt_in       = tgt_ff;
      lvl_in       = lvl_ff;
      lim_in       = lim_ff;
      cur_in       = cur_ff;
      cm_in        = cm_ff;
      blk_in       = blk_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      tree_we      = 1'b0;
      tree_wa      = cur_ff;
      tree_wd      = '0;
      tree_re      = 1'b0;
      tree_ra      = sib;
      meta_we      = 1'b0;
      meta_wa      = blk_ff;
      meta_wd      = '0;
      meta_re      = 1'b0;
      meta_ra      = BLK_W'(off >> BSH);

      unique case (state_ff)
         S_CLEAR: begin
            tree_we = 1'b1;
            tree_wa = clr_ff;
            tree_wd = (clr_ff == '0) ? (MASK_W'(1) << ORDERS) : '0;
            meta_we = (clr_ff < NODE_W'(NBLK));
            meta_wa = clr_ff[BLK_W-1:0];
            clr_in  = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(NODES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               op_in  = req_payload.command;
               rsp_in = '{status: ST_OK, block_offset: '0, block_order: '0};
               if (req_payload.command == CMD_ALLOC) begin
                  ord_in = first_order(req_payload.size_bytes);
                  if (req_payload.size_bytes > SIZE_W'(POOL_BYTES)) begin
                     rsp_in.status = ST_NO_SPACE;
                     rsp_valid_in  = 1'b1;
                  end else begin
                     tree_re  = 1'b1;
                     tree_ra  = '0;
                     state_in = S_A_ROOT;
                  end
               end else begin
                  blk_in = BLK_W'(off >> BSH);
                  if (off > OFF_W'(POOL_BYTES - BLOCK_BYTES) || off[BSH-1:0] != '0) begin
                     rsp_in.status = ST_BAD_FREE;
                     rsp_valid_in  = 1'b1;
                  end else begin
                     meta_re  = 1'b1;
                     state_in = S_F_CHK;
                  end
               end
            end
         end
         S_A_ROOT: begin
            if (cand == '0) begin
               rsp_in.status = ST_NO_SPACE;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               tgt_in   = low_k;
               cur_in   = '0;
               lvl_in   = LVL_W'(ORDERS);
               blk_in   = '0;
               state_in = S_A_DN;
            end
         end
         S_A_DN: begin
            if (lvl_ff == tgt_ff) begin
               state_in = S_A_FOUND;
            end else begin
               tree_re  = 1'b1;
               tree_ra  = left;
               state_in = S_A_DNCHK;
            end
         end
         S_A_DNCHK: begin
            // go left while the left subtree still has a free block of the target order
            lvl_in = lvl_ff - LVL_W'(1);
            if (tree_rd[tgt_ff]) begin
               cur_in = left;
            end else begin
               cur_in = left + NODE_W'(1);
               blk_in = blk_ff | (BLK_W'(1) << (lvl_ff - LVL_W'(1)));
            end
            state_in = S_A_DN;
         end
         S_A_FOUND: begin
            tree_we  = 1'b1;
            tree_wa  = node_index(ord_ff, blk_ff);
            tree_wd  = '0;
            meta_we  = 1'b1;
            meta_wd  = '{allocated: 1'b1, order: ORD_W'(ord_ff)};
            cur_in   = node_index(ord_ff, blk_ff);
            cm_in    = '0;
            lvl_in   = ord_ff;
            lim_in   = tgt_ff;
            state_in = S_UP;
         end
         S_F_CHK: begin
            if (!meta_rd.allocated) begin
               rsp_in.status = ST_BAD_FREE;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               meta_we  = 1'b1;
               meta_wd  = '0;
               cur_in   = node_index(fk, blk_ff);
               lvl_in   = fk;
               state_in = S_F_MRG;
            end
         end
         S_F_MRG: begin
            if (lvl_ff == LVL_W'(ORDERS)) begin
               state_in = S_F_SET;
            end else begin
               tree_re  = 1'b1;
               state_in = S_F_MCHK;
            end
         end
         S_F_MCHK: begin
            if (tree_rd[lvl_ff]) begin
               tree_we  = 1'b1;
               tree_wa  = sib;
               cur_in   = par;
               lvl_in   = lvl_ff + LVL_W'(1);
               state_in = S_F_MCLR;
            end else begin
               state_in = S_F_SET;
            end
         end
         S_F_MCLR: begin
            // the merged parent lies inside the new free block until proven final
            tree_we  = 1'b1;
            state_in = S_F_MRG;
         end
         S_F_SET: begin
            tree_we  = 1'b1;
            tree_wd  = lvl_bit;
            cm_in    = lvl_bit;
            lim_in   = lvl_ff;
            state_in = S_UP;
         end
         S_UP: begin
            if (lvl_ff == LVL_W'(ORDERS)) begin
               rsp_in.status = ST_OK;
               if (op_ff == CMD_ALLOC) begin
                  rsp_in.block_offset = OFF_W'(blk_ff) << BSH;
                  rsp_in.block_order  = ORD_W'(ord_ff);
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (lvl_ff < lim_ff) begin
               // upper half of a split becomes free
               tree_we  = 1'b1;
               tree_wa  = sib;
               tree_wd  = lvl_bit;
               state_in = S_UP_PAR;
            end else begin
               tree_re  = 1'b1;
               state_in = S_UP_WAIT;
            end
         end
         S_UP_PAR: begin
            tree_we  = 1'b1;
            tree_wa  = par;
            tree_wd  = cm_ff | lvl_bit;
            cm_in    = cm_ff | lvl_bit;
            cur_in   = par;
            lvl_in   = lvl_ff + LVL_W'(1);
            state_in = S_UP;
         end
         S_UP_WAIT: begin
            tree_we  = 1'b1;
            tree_wa  = par;
            tree_wd  = cm_ff | tree_rd;
            cm_in    = cm_ff | tree_rd;
            cur_in   = par;
            lvl_in   = lvl_ff + LVL_W'(1);
            state_in = S_UP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         lvl_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         lvl_ff       <= lvl_in;
      end
      op_ff  <= op_in;
      ord_ff <= ord_in;
      tgt_ff <= tgt_in;
      lim_ff <= lim_in;
      cur_ff <= cur_in;
      cm_ff  <= cm_in;
      blk_ff <= blk_in;
      rsp_ff <= rsp_in;
   end

   // a response goes out only while the sequencer is idle
   `BBA_ASSERT_IMPL(a_rsp_at_idle, clock, reset, rsp_valid, !busy)
   // no memory is written while idle
   `BBA_ASSERT_IMPL(a_no_write_idle, clock, reset, !busy, !tree_we && !meta_we)
   // the tree walk stays within the orders
   `BBA_ASSERT_IMPL(a_lvl_range, clock, reset, busy && state_ff != S_CLEAR,
                    lvl_ff <= LVL_W'(ORDERS))
   // an accepted request that is not rejected at once keeps the block busy
   `BBA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy || rsp_valid)

endmodule
